// File: hdl/lfupr_pkg.sv
// Shared types and constants for the LFU page replacement block.
package lfupr_pkg;

  localparam int PAGE_W      = 8;
  localparam int COUNT_W     = 16;
  localparam int SLOT_W      = 2;
  localparam int ENTRIES_DEF = 4;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  // Page zero marks an empty table entry.
  localparam page_t  EMPTY_PAGE = '0;
  localparam count_t COUNT_MAX  = '1;
  localparam count_t COUNT_ONE  = count_t'(1);

  // Flags collected by the table scan.
  typedef struct packed {
    logic found;
    logic has_free;
  } scan_flags_t;

endpackage

// File: hdl/lfupr_table.sv
// Page and count storage with per-entry valid bits and a registered read port.
module lfupr_table #(
  parameter int ENTRIES = lfupr_pkg::ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IDX_W-1:0]    raddr,
  output lfupr_pkg::page_t    rd_page,
  output lfupr_pkg::count_t   rd_count,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  lfupr_pkg::page_t    wpage,
  input  lfupr_pkg::count_t   wcount
);
  import lfupr_pkg::*;

  page_t               page_mem  [ENTRIES];
  count_t              count_mem [ENTRIES];
  logic [ENTRIES-1:0]  valid;
  page_t               page_q;
  count_t              count_q;
  logic                valid_q;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      page_mem[waddr]  <= wpage;
      count_mem[waddr] <= wcount;
    end
    page_q  <= page_mem[raddr];
    count_q <= count_mem[raddr];
  end

  // Valid bits stand in for the cleared table after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      valid_q <= valid[raddr];
    end
  end

  // An entry never written reads as empty with a zero count.
  assign rd_page  = valid_q ? page_q  : EMPTY_PAGE;
  assign rd_count = valid_q ? count_q : '0;

endmodule

// File: hdl/lfupr_scan.sv
// Shared compare unit that examines one table entry per cycle.
module lfupr_scan #(
  parameter int ENTRIES = lfupr_pkg::ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   cmp_vld,
  input  logic [IDX_W-1:0]       cmp_idx,
  input  lfupr_pkg::page_t       ref_page,
  input  lfupr_pkg::page_t       rd_page,
  input  lfupr_pkg::count_t      rd_count,
  output lfupr_pkg::scan_flags_t flags,
  output logic [IDX_W-1:0]       found_idx,
  output lfupr_pkg::count_t      found_cnt,
  output logic [IDX_W-1:0]       free_idx,
  output logic [IDX_W-1:0]       victim_idx,
  output lfupr_pkg::page_t       victim_page
);
  import lfupr_pkg::*;

  count_t min_cnt;

  // Flags restart with every new transaction.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
    end else if (cmp_vld) begin
      if (!flags.found && rd_page == ref_page) begin
        flags.found <= 1'b1;
      end
      if (!flags.has_free && rd_page == EMPTY_PAGE) begin
        flags.has_free <= 1'b1;
      end
    end
  end

  // First match, first free entry and first entry with the lowest count.
  always_ff @(posedge clk) begin
    if (cmp_vld) begin
      if (!flags.found && rd_page == ref_page) begin
        found_idx <= cmp_idx;
        found_cnt <= rd_count;
      end
      if (!flags.has_free && rd_page == EMPTY_PAGE) begin
        free_idx <= cmp_idx;
      end
      if (cmp_idx == '0 || rd_count < min_cnt) begin
        victim_idx  <= cmp_idx;
        victim_page <= rd_page;
        min_cnt     <= rd_count;
      end
    end
  end

endmodule

// File: hdl/lfu_page_replacement.sv
// Top level of the LFU page replacement block: sequencer and result register.
//
// Input channel: in_valid, in_stall and page, one page reference per
// transaction. Output channel: out_valid, out_stall and the fields hit,
// slot, evicted, evicted_page and use_count, one result per reference.
// The table is read one entry per cycle through a single memory read port,
// and one compare unit checks each entry for a match, a free place and the
// lowest count. After acceptance an item passes the scan, drain and update
// states before its result is written to the output register, and the next
// item is accepted only once that result has been written.
// in_stall stays high from acceptance until the result has been written.
// A result waits in the output register while out_stall is high; the block
// still takes and scans the next reference, and holds it at the update step
// until the register is free. Page zero is reserved: it leaves the table
// unchanged and returns all-zero fields.
// Reset clears the table through per-entry valid bits, and in_stall is high
// while rst is high.
module lfu_page_replacement #(
  parameter int ENTRIES = lfupr_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lfupr_pkg::page_t   page,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output lfupr_pkg::slot_t   slot,
  output logic               evicted,
  output lfupr_pkg::page_t   evicted_page,
  output lfupr_pkg::count_t  use_count
);
  import lfupr_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] addr;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  page_t            ref_page;

  page_t            rd_page;
  count_t           rd_count;
  scan_flags_t      flags;
  logic [IDX_W-1:0] found_idx;
  count_t           found_cnt;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] victim_idx;
  page_t            victim_page;

  logic             accept;
  logic             out_free;
  logic             finish;
  logic             we;
  logic [IDX_W-1:0] waddr;
  count_t           wcount;
  logic             res_hit;
  logic             res_evicted;
  page_t            res_evicted_page;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == S_UPDATE) && out_free;

  lfupr_table #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_table (
    .clk      (clk),
    .rst      (rst),
    .raddr    (addr),
    .rd_page  (rd_page),
    .rd_count (rd_count),
    .we       (we),
    .waddr    (waddr),
    .wpage    (ref_page),
    .wcount   (wcount)
  );

  lfupr_scan #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (accept),
    .cmp_vld     (cmp_vld),
    .cmp_idx     (cmp_idx),
    .ref_page    (ref_page),
    .rd_page     (rd_page),
    .rd_count    (rd_count),
    .flags       (flags),
    .found_idx   (found_idx),
    .found_cnt   (found_cnt),
    .free_idx    (free_idx),
    .victim_idx  (victim_idx),
    .victim_page (victim_page)
  );

  // Sequencer: entry zero is read at acceptance, the rest during the scan.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (addr == LAST_IDX) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_UPDATE;
      S_UPDATE: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      addr    <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (accept || state == S_SCAN) begin
        cmp_vld <= 1'b1;
        cmp_idx <= addr;
        addr    <= addr + 1'b1;
      end else begin
        cmp_vld <= 1'b0;
        addr    <= '0;
      end
    end
  end

  // The reference is held for the whole transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      ref_page <= page;
    end
  end

  // Table update: hit, fill of a free entry, or replacement of the victim.
  always_comb begin
    res_hit          = 1'b0;
    res_evicted      = 1'b0;
    res_evicted_page = EMPTY_PAGE;
    waddr            = victim_idx;
    wcount           = COUNT_ONE;
    if (flags.found) begin
      res_hit = 1'b1;
      waddr   = found_idx;
      wcount  = (found_cnt == COUNT_MAX) ? COUNT_MAX : found_cnt + COUNT_ONE;
    end else if (flags.has_free) begin
      waddr = free_idx;
    end else begin
      res_evicted      = 1'b1;
      res_evicted_page = victim_page;
    end
  end

  assign we = finish && (ref_page != EMPTY_PAGE);

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (ref_page == EMPTY_PAGE) begin
        hit          <= 1'b0;
        slot         <= '0;
        evicted      <= 1'b0;
        evicted_page <= EMPTY_PAGE;
        use_count    <= '0;
      end else begin
        hit          <= res_hit;
        slot         <= SLOT_W'(waddr);
        evicted      <= res_evicted;
        evicted_page <= res_evicted_page;
        use_count    <= wcount;
      end
    end
  end

endmodule

// File: hdl/lfupr_checker.sv
// Port-level checks for the LFU page replacement block, bound to the top level.
module lfupr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               hit,
  input lfupr_pkg::slot_t   slot,
  input logic               evicted,
  input lfupr_pkg::page_t   evicted_page,
  input lfupr_pkg::count_t  use_count
);
  import lfupr_pkg::*;

  // A waiting result keeps its fields until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(slot) &&
      $stable(evicted) && $stable(evicted_page) && $stable(use_count))
    else $error("output transaction changed while stalled");

  // A hit never replaces a page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and eviction reported together");

  // Without an eviction the evicted page reads as empty.
  a_evict_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_page == EMPTY_PAGE)
    else $error("evicted page set without eviction");

  // A hit count is at least two; a miss leaves a count of one at most.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit ? (use_count > COUNT_ONE) : (use_count <= COUNT_ONE)))
    else $error("use count inconsistent with hit");

  // After accepting a reference the block is busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted back to back");

endmodule

bind lfu_page_replacement lfupr_checker u_lfupr_checker (.*);

// File: verif/lfu_table_checker.sv
// Checker that predicts and compares every LFU page lookup result.
module lfu_table_checker #(
  parameter int ENTRIES = lfupr_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  lfupr_pkg::page_t   page,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               hit,
  input  lfupr_pkg::slot_t   slot,
  input  logic               evicted,
  input  lfupr_pkg::page_t   evicted_page,
  input  lfupr_pkg::count_t  use_count,
  output int                 fail_count,
  output int                 pending
);
  import lfupr_pkg::*;

  // Result fields of one lookup, in port order.
  typedef struct packed {
    logic   hit;
    slot_t  slot;
    logic   evicted;
    page_t  evicted_page;
    count_t use_count;
  } lookup_t;

  // One expected result, tagged with the page that caused it.
  typedef struct {
    page_t   ref_page;
    lookup_t res;
  } expected_t;

  // Shadow copy of the resident pages and their use counts.
  page_t     shadow_page [ENTRIES];
  count_t    shadow_count[ENTRIES];
  expected_t lookups_due[$];
  int        errors = 0;
  int        shown  = 0;

  // Applies one page reference to the shadow table and returns its result.
  function automatic lookup_t lookup_page(input page_t p);
    lookup_t r;
    int      match_idx;
    int      free_idx;
    int      low_idx;
    r         = '0;
    match_idx = -1;
    free_idx  = -1;
    low_idx   = 0;
    if (p == EMPTY_PAGE) begin
      return r;
    end
    // Full scan: first match, first free entry, first entry of lowest count.
    for (int k = 0; k < ENTRIES; k++) begin
      if (match_idx < 0 && shadow_page[k] == p) begin
        match_idx = k;
      end
      if (free_idx < 0 && shadow_page[k] == EMPTY_PAGE) begin
        free_idx = k;
      end
      if (shadow_count[k] < shadow_count[low_idx]) begin
        low_idx = k;
      end
    end
    if (match_idx >= 0) begin
      r.hit = 1'b1;
      if (shadow_count[match_idx] != COUNT_MAX) begin
        shadow_count[match_idx] = shadow_count[match_idx] + COUNT_ONE;
      end
      low_idx = match_idx;
    end else if (free_idx >= 0) begin
      shadow_page[free_idx]  = p;
      shadow_count[free_idx] = COUNT_ONE;
      low_idx = free_idx;
    end else begin
      r.evicted               = 1'b1;
      r.evicted_page          = shadow_page[low_idx];
      shadow_page[low_idx]    = p;
      shadow_count[low_idx]   = COUNT_ONE;
    end
    r.slot      = slot_t'(low_idx);
    r.use_count = shadow_count[low_idx];
    return r;
  endfunction

  // Watches both channels; results are checked before new references are queued.
  always @(posedge clk) begin
    lookup_t   got;
    expected_t want;
    if (rst) begin
      for (int k = 0; k < ENTRIES; k++) begin
        shadow_page[k]  = EMPTY_PAGE;
        shadow_count[k] = '0;
      end
      lookups_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {hit, slot, evicted, evicted_page, use_count};
        if (lookups_due.size() == 0) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result transaction: hit=%0b slot=%0d evicted=%0b",
                     hit, slot, evicted, " evicted_page=%0d use_count=%0d",
                     evicted_page, use_count);
          end
        end else begin
          want = lookups_due.pop_front();
          if (got.hit !== want.res.hit || got.slot !== want.res.slot ||
              got.evicted !== want.res.evicted ||
              got.evicted_page !== want.res.evicted_page ||
              got.use_count !== want.res.use_count) begin
            errors++;
            if (shown < 10) begin
              shown++;
              $display("mismatch for page %0d: expected hit=%0b slot=%0d evicted=%0b",
                       want.ref_page, want.res.hit, want.res.slot, want.res.evicted,
                       " evicted_page=%0d use_count=%0d", want.res.evicted_page,
                       want.res.use_count);
              $display("  got hit=%0b slot=%0d evicted=%0b evicted_page=%0d use_count=%0d",
                       got.hit, got.slot, got.evicted, got.evicted_page, got.use_count);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.ref_page = page;
        want.res      = lookup_page(page);
        lookups_due.push_back(want);
      end
    end
    fail_count <= errors;
    pending    <= lookups_due.size();
  end

endmodule

// File: verif/tb_lfu_page_replacement.sv
// Testbench top for the LFU page replacement block: stimulus, stalls and verdict.
module tb_lfu_page_replacement;
  import lfupr_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_REFS = 1400;
  localparam int HOT_REFS    = 24;

  logic   clk;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  page_t  page      = EMPTY_PAGE;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   hit;
  slot_t  slot;
  logic   evicted;
  page_t  evicted_page;
  count_t use_count;
  int     fail_count;
  int     pending;

  // Sender burst control and receiver stall control.
  int burst_left = 0;
  int gap_max    = 12;
  bit calm       = 1'b0;
  int stall_pct  = 0;
  int stall_left = 0;
  int cycle_cnt  = 0;

  lfu_page_replacement i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .page         (page),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .slot         (slot),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .use_count    (use_count)
  );

  lfu_table_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .page         (page),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .slot         (slot),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .use_count    (use_count),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stall: a new stall rate is drawn each time its random hold runs out.
  always @(posedge clk) begin
    int pct;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        case ($urandom_range(3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 50;
          default: pct = 90;
        endcase
        stall_pct  = calm ? 10 : pct;
        stall_left = $urandom_range(300, 40);
      end else begin
        stall_left--;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Ends the run with a failure once the cycle limit is reached.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  // Sends one page reference as a transaction, after a random gap between bursts.
  task automatic send_ref(input page_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(16, 1);
    end
    in_valid <= 1'b1;
    page     <= p;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Holds the sender until every expected result has come back.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    page_t dir_pages[$];
    page_t work_set[8];
    int    set_size;
    int    pick;
    page_t hot;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reserved page on an empty and a full table, fills, hits,
    // evictions with ties, and single-bit pages.
    dir_pages = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd127, 8'd255, 8'd255, 8'd1, 8'd0,
                  8'd200, 8'd85, 8'd170, 8'd170, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32,
                  8'd64, 8'd1};
    foreach (dir_pages[i]) send_ref(dir_pages[i]);

    // Let the block drain completely once.
    in_valid <= 1'b0;
    wait_drained();

    // Random: mostly a small working set so that hits and evictions mix.
    set_size = 5;
    for (int n = 0; n < RANDOM_REFS; n++) begin
      if (n % 80 == 0) begin
        set_size = $urandom_range(8, 3);
        foreach (work_set[i]) work_set[i] = page_t'($urandom_range(255, 1));
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_ref(EMPTY_PAGE);
      end else if (pick < 15) begin
        send_ref(page_t'($urandom_range(255, 1)));
      end else begin
        send_ref(work_set[$urandom_range(set_size - 1)]);
      end
    end

    // Hot page: one page hit back to back so that its count stands above the rest.
    hot     = page_t'($urandom_range(223, 1));
    gap_max = 0;
    calm    = 1'b1;
    for (int n = 0; n < HOT_REFS; n++) send_ref(hot);

    // Fresh misses must evict around the hot entry.
    for (int n = 0; n < 6; n++) send_ref(page_t'(8'd224 + n));

    in_valid <= 1'b0;
    wait_drained();
    repeat (2 * ENTRIES_DEF + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lfupr_pkg.sv
hdl/lfupr_table.sv
hdl/lfupr_scan.sv
hdl/lfu_page_replacement.sv
hdl/lfupr_checker.sv
verif/lfu_table_checker.sv
verif/tb_lfu_page_replacement.sv
